### design/ctt_pkg.sv
package ctt_pkg;

  // Field and state widths
  localparam int BYTE_W   = 8;
  localparam int DIM_W    = 10;
  localparam int COORD_W  = 11;
  localparam int NUM_W    = 16;
  localparam int SUM_W    = ((COORD_W > NUM_W) ? COORD_W : NUM_W) + 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};

  localparam logic signed [SUM_W-1:0] S_ZERO = SUM_W'(0);
  localparam logic signed [SUM_W-1:0] S_ONE  = SUM_W'(1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

  localparam logic [DIM_W-1:0] ROWS_RESET = 10'd24;
  localparam logic [DIM_W-1:0] COLS_RESET = 10'd80;

  // Control bytes
  localparam logic [BYTE_W-1:0] CH_BEL = 8'h07;
  localparam logic [BYTE_W-1:0] CH_BS  = 8'h08;
  localparam logic [BYTE_W-1:0] CH_VT  = 8'h0B;
  localparam logic [BYTE_W-1:0] CH_FF  = 8'h0C;
  localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_ESC = 8'h1B;

  // Printable bytes with a meaning in sequences
  localparam logic [BYTE_W-1:0] CH_SEVEN  = 8'h37;
  localparam logic [BYTE_W-1:0] CH_EIGHT  = 8'h38;
  localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;
  localparam logic [BYTE_W-1:0] CH_SEMI   = 8'h3B;
  localparam logic [BYTE_W-1:0] CH_AT     = 8'h40;
  localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_RBRACK = 8'h5D;
  localparam logic [BYTE_W-1:0] CH_GRAVE  = 8'h60;
  localparam logic [BYTE_W-1:0] CH_UP_A   = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UP_B   = 8'h42;
  localparam logic [BYTE_W-1:0] CH_UP_C   = 8'h43;
  localparam logic [BYTE_W-1:0] CH_UP_D   = 8'h44;
  localparam logic [BYTE_W-1:0] CH_UP_E   = 8'h45;
  localparam logic [BYTE_W-1:0] CH_UP_F   = 8'h46;
  localparam logic [BYTE_W-1:0] CH_UP_G   = 8'h47;
  localparam logic [BYTE_W-1:0] CH_UP_H   = 8'h48;
  localparam logic [BYTE_W-1:0] CH_UP_M   = 8'h4D;
  localparam logic [BYTE_W-1:0] CH_UP_Z   = 8'h5A;
  localparam logic [BYTE_W-1:0] CH_LO_A   = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LO_C   = 8'h63;
  localparam logic [BYTE_W-1:0] CH_LO_D   = 8'h64;
  localparam logic [BYTE_W-1:0] CH_LO_E   = 8'h65;
  localparam logic [BYTE_W-1:0] CH_LO_F   = 8'h66;
  localparam logic [BYTE_W-1:0] CH_LO_R   = 8'h72;
  localparam logic [BYTE_W-1:0] CH_LO_S   = 8'h73;
  localparam logic [BYTE_W-1:0] CH_LO_U   = 8'h75;
  localparam logic [BYTE_W-1:0] CH_LO_X   = 8'h78;
  localparam logic [BYTE_W-1:0] CH_LO_Z   = 8'h7A;

  // Cursor, saved cursor and scroll region
  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row_sv;
    logic [COORD_W-1:0] col_sv;
    logic [DIM_W-1:0]   top;
    logic [DIM_W-1:0]   bot;
  } cursor_t;

  // Collected CSI parameters
  typedef struct packed {
    logic [NUM_W-1:0] n1;
    logic [NUM_W-1:0] n2;
    logic             seen1;
    logic             seen2;
  } csi_parm_t;

  // Append one decimal digit, saturating
  function automatic logic [NUM_W-1:0] add_digit(input logic [NUM_W-1:0] v,
                                                 input logic [3:0] d);
    logic [NUM_W+3:0] r;
    r = ({4'b0, v} << 3) + ({4'b0, v} << 1) + {{NUM_W{1'b0}}, d};
    return (r > {4'b0, NUM_MAX}) ? NUM_MAX : r[NUM_W-1:0];
  endfunction

  // Clamp a signed value into lo..hi
  function automatic logic signed [SUM_W-1:0] clamp_s(input logic signed [SUM_W-1:0] lo,
                                                      input logic signed [SUM_W-1:0] v,
                                                      input logic signed [SUM_W-1:0] hi);
    logic signed [SUM_W-1:0] r;
    r = v;
    if (v < lo) r = lo;
    else if (v > hi) r = hi;
    return r;
  endfunction

endpackage

### design/ctt_if.sv
interface ctt_in_if;
  import ctt_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

interface ctt_out_if;
  import ctt_pkg::*;

  logic               valid;
  logic               ready;
  logic [DIM_W-1:0]   cursor_row;
  logic [DIM_W:0]     cursor_col;
  logic [DIM_W-1:0]   region_top;
  logic [DIM_W-1:0]   region_bottom;
  logic               report_request;
  logic               sequence_done;

  modport source (output valid, output cursor_row, output cursor_col, output region_top,
                  output region_bottom, output report_request, output sequence_done,
                  input ready);
  modport sink   (input valid, input cursor_row, input cursor_col, input region_top,
                  input region_bottom, input report_request, input sequence_done,
                  output ready);
endinterface

### design/terminal_cursor_tracker_top.sv
// Channel  | Dir | Payload                                         | Handshake
// in_ch    | in  | stream_byte                                     | valid/ready
// out_ch   | out | cursor_row, cursor_col, region_top,             | valid/ready
//          |     | region_bottom, report_request, sequence_done    |
// cfg      | in  | cfg_index, cfg_wdata                            | cfg_we, no wait
//
// One byte is taken per cycle unless the output stalls; each byte yields one
// result word (input register, then the state update into the result register).
// Synchronous active-low reset homes the cursor, clears the region and
// parameters, returns the parser to ground and sets the screen to 24 x 80.
// A stalled output holds its word; the input register still drains into the
// result register the cycle out_ch.ready returns, so in_ch.ready follows it.
module terminal_cursor_tracker_top (
  input  logic                           clk,
  input  logic                           rst_n,
  ctt_in_if.sink                         in_ch,
  ctt_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [ctt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ctt_pkg::DIM_W-1:0]      cfg_wdata
);
  import ctt_pkg::*;

  typedef enum logic [1:0] {PH_GROUND, PH_ESCAPE, PH_CSI, PH_OSC} phase_t;
  typedef enum logic [1:0] {NS_FIRST, NS_SECOND, NS_STOP} num_stage_t;

  logic [DIM_W-1:0]  rows_r, cols_r, rows_eff, cols_eff;
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  cursor_t           cur_r, cur_nxt, csi_cur;
  csi_parm_t         parm_r, parm_nxt;
  phase_t            phase_r, phase_nxt;
  num_stage_t        stage_r, stage_nxt;
  logic              report, done;
  logic              advance, in_fire, step_en;
  logic [COORD_W:0]  row_inc, row_dec;
  logic              byte_is_letter, byte_is_numeral;

  logic              out_valid_r;
  logic [DIM_W-1:0]  out_row_r, out_top_r, out_bot_r;
  logic [DIM_W:0]    out_col_r;
  logic              out_report_r, out_done_r;

  // Handshake
  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign step_en     = s1_valid_r && advance;

  assign rows_eff = (rows_r == '0) ? DIM_W'(1) : rows_r;
  assign cols_eff = (cols_r == '0) ? DIM_W'(1) : cols_r;

  assign row_inc  = {1'b0, cur_r.row} + (COORD_W+1)'(1);
  assign row_dec  = {1'b0, cur_r.row} - (COORD_W+1)'(1);
  assign byte_is_letter  = ((s1_byte_r >= CH_UP_A) && (s1_byte_r <= CH_UP_Z)) ||
                           ((s1_byte_r >= CH_LO_A) && (s1_byte_r <= CH_LO_Z));
  assign byte_is_numeral = (s1_byte_r >= CH_ZERO) && (s1_byte_r <= CH_NINE);

  ctt_csi_exec u_csi_exec (
    .fin_byte (s1_byte_r),
    .cur      (cur_r),
    .parm     (parm_r),
    .rows     (rows_eff),
    .cols     (cols_eff),
    .cur_nxt  (csi_cur)
  );

  // Parse one byte and update the cursor
  always_comb begin
    cur_nxt   = cur_r;
    parm_nxt  = parm_r;
    phase_nxt = phase_r;
    stage_nxt = stage_r;
    report    = 1'b0;
    done      = 1'b0;
    case (phase_r)
      PH_GROUND: begin
        if (s1_byte_r == CH_BS) begin
          cur_nxt.col = (cur_r.col > COORD_W'(1)) ? cur_r.col - COORD_W'(1) : COORD_W'(1);
        end else if (s1_byte_r == CH_VT || s1_byte_r == CH_FF) begin
          cur_nxt.row = (row_inc < {{(COORD_W+1-DIM_W){1'b0}}, rows_eff}) ?
                        row_inc[COORD_W-1:0] : {{(COORD_W-DIM_W){1'b0}}, rows_eff};
        end else if (s1_byte_r == CH_CR) begin
          cur_nxt.col = COORD_W'(1);
        end else if (s1_byte_r == CH_ESC) begin
          phase_nxt = PH_ESCAPE;
        end
      end
      PH_ESCAPE: begin
        phase_nxt = PH_GROUND;
        done      = 1'b1;
        case (s1_byte_r)
          CH_SEVEN: begin
            cur_nxt.row_sv = cur_r.row;
            cur_nxt.col_sv = cur_r.col;
          end
          CH_EIGHT: begin
            cur_nxt.row = cur_r.row_sv;
            cur_nxt.col = cur_r.col_sv;
          end
          CH_LO_C: begin
            cur_nxt.row    = COORD_W'(1);
            cur_nxt.col    = COORD_W'(1);
            cur_nxt.row_sv = COORD_W'(1);
            cur_nxt.col_sv = COORD_W'(1);
          end
          CH_UP_D, CH_UP_E: begin
            cur_nxt.row = (row_inc < {{(COORD_W+1-DIM_W){1'b0}}, rows_eff}) ?
                          row_inc[COORD_W-1:0] : {{(COORD_W-DIM_W){1'b0}}, rows_eff};
            if (s1_byte_r == CH_UP_E) cur_nxt.col = COORD_W'(1);
          end
          CH_UP_M: begin
            if (row_dec == '0)
              cur_nxt.row = COORD_W'(1);
            else if (row_dec > {{(COORD_W+1-DIM_W){1'b0}}, rows_eff})
              cur_nxt.row = {{(COORD_W-DIM_W){1'b0}}, rows_eff};
            else
              cur_nxt.row = row_dec[COORD_W-1:0];
          end
          CH_LBRACK: begin
            phase_nxt = PH_CSI;
            done      = 1'b0;
            parm_nxt  = '0;
            stage_nxt = NS_FIRST;
          end
          CH_RBRACK: begin
            phase_nxt = PH_OSC;
            done      = 1'b0;
          end
          default: ;
        endcase
      end
      PH_CSI: begin
        if (s1_byte_r == CH_AT || s1_byte_r == CH_GRAVE || s1_byte_r == CH_RBRACK) begin
          phase_nxt = PH_GROUND;
          done      = 1'b1;
        end else if (s1_byte_r == CH_LO_C || s1_byte_r == CH_LO_X) begin
          phase_nxt = PH_GROUND;
          done      = 1'b1;
          report    = 1'b1;
        end else if (byte_is_letter) begin
          cur_nxt   = csi_cur;
          phase_nxt = PH_GROUND;
          done      = 1'b1;
        end else if (byte_is_numeral) begin
          if (stage_r == NS_FIRST) begin
            parm_nxt.n1    = add_digit(parm_r.n1, s1_byte_r[3:0]);
            parm_nxt.seen1 = 1'b1;
          end else if (stage_r == NS_SECOND) begin
            parm_nxt.n2    = add_digit(parm_r.n2, s1_byte_r[3:0]);
            parm_nxt.seen2 = 1'b1;
          end
        end else if (s1_byte_r == CH_SEMI) begin
          stage_nxt = (stage_r == NS_FIRST) ? NS_SECOND : NS_STOP;
        end else begin
          stage_nxt = NS_STOP;
        end
      end
      default: begin
        // OSC body: only BEL or ESC matter
        if (s1_byte_r == CH_BEL) begin
          phase_nxt = PH_GROUND;
          done      = 1'b1;
        end else if (s1_byte_r == CH_ESC) begin
          phase_nxt = PH_ESCAPE;
        end
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= ROWS_RESET;
      cols_r <= COLS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROWS: rows_r <= cfg_wdata;
        CFG_COLS: cols_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) s1_byte_r <= in_ch.stream_byte;
  end

  // Tracker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r   <= '{row: COORD_W'(1), col: COORD_W'(1), row_sv: COORD_W'(1),
                   col_sv: COORD_W'(1), top: DIM_W'(1), bot: '0};
      parm_r  <= '0;
      phase_r <= PH_GROUND;
      stage_r <= NS_FIRST;
    end else if (step_en) begin
      cur_r   <= cur_nxt;
      parm_r  <= parm_nxt;
      phase_r <= phase_nxt;
      stage_r <= stage_nxt;
    end
  end

  // Result register: hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_row_r    <= cur_nxt.row[DIM_W-1:0];
      out_col_r    <= cur_nxt.col[DIM_W:0];
      out_top_r    <= cur_nxt.top;
      out_bot_r    <= cur_nxt.bot;
      out_report_r <= report;
      out_done_r   <= done;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.cursor_row     = out_row_r;
  assign out_ch.cursor_col     = out_col_r;
  assign out_ch.region_top     = out_top_r;
  assign out_ch.region_bottom  = out_bot_r;
  assign out_ch.report_request = out_report_r;
  assign out_ch.sequence_done  = out_done_r;

endmodule

### design/ctt_csi_exec.sv
module ctt_csi_exec (
  input  logic [ctt_pkg::BYTE_W-1:0] fin_byte,
  input  ctt_pkg::cursor_t           cur,
  input  ctt_pkg::csi_parm_t         parm,
  input  logic [ctt_pkg::DIM_W-1:0]  rows,
  input  logic [ctt_pkg::DIM_W-1:0]  cols,
  output ctt_pkg::cursor_t           cur_nxt
);
  import ctt_pkg::*;

  logic signed [SUM_W-1:0] row, col, top, bot;
  logic signed [SUM_W-1:0] n, m, n2, rows_s, cols_s;
  logic signed [SUM_W-1:0] row_c, col_c, top_c, bot_c;
  logic                    both;

  // Apply one CSI final, then clamp to the screen
  always_comb begin
    rows_s = $signed({{(SUM_W-DIM_W){1'b0}}, rows});
    cols_s = $signed({{(SUM_W-DIM_W){1'b0}}, cols});
    row    = $signed({{(SUM_W-COORD_W){1'b0}}, cur.row});
    col    = $signed({{(SUM_W-COORD_W){1'b0}}, cur.col});
    top    = $signed({{(SUM_W-DIM_W){1'b0}}, cur.top});
    bot    = $signed({{(SUM_W-DIM_W){1'b0}}, cur.bot});
    n      = parm.seen1 ? $signed({{(SUM_W-NUM_W){1'b0}}, parm.n1}) : S_ZERO;
    n2     = $signed({{(SUM_W-NUM_W){1'b0}}, parm.n2});
    m      = (n == S_ZERO) ? S_ONE : n;
    both   = parm.seen1 && parm.seen2;
    cur_nxt = cur;

    case (fin_byte)
      CH_UP_A: row = row - m;
      CH_UP_B, CH_LO_E: row = row + m;
      CH_UP_C, CH_LO_A: col = col + m;
      CH_UP_D: col = col - m;
      CH_UP_E: begin
        row = row + m;
        col = S_ONE;
      end
      CH_UP_F: begin
        row = row - m;
        col = S_ONE;
      end
      CH_UP_G: col = m;
      CH_UP_H, CH_LO_F: begin
        if (both) begin
          row = n;
          col = n2;
        end else if (parm.seen1) begin
          row = n;
          col = S_ONE;
        end else begin
          row = S_ONE;
          col = S_ONE;
        end
      end
      CH_LO_D: row = n;
      CH_LO_R: begin
        if (both) begin
          top = n;
          bot = n2;
        end else if (parm.seen1) begin
          top = n;
          bot = rows_s;
        end else begin
          top = S_ONE;
          bot = rows_s;
        end
        row = S_ONE;
        col = S_ONE;
      end
      CH_LO_S: begin
        cur_nxt.row_sv = cur.row;
        cur_nxt.col_sv = cur.col;
      end
      CH_LO_U: begin
        row = $signed({{(SUM_W-COORD_W){1'b0}}, cur.row_sv});
        col = $signed({{(SUM_W-COORD_W){1'b0}}, cur.col_sv});
      end
      default: ;
    endcase

    row_c = clamp_s(S_ONE, row, rows_s);
    col_c = clamp_s(S_ONE, col, cols_s + S_ONE);
    top_c = clamp_s(S_ONE, top, rows_s);
    bot_c = (bot != S_ZERO) ? clamp_s(S_ONE, bot, rows_s) : rows_s;

    cur_nxt.row = row_c[COORD_W-1:0];
    cur_nxt.col = col_c[COORD_W-1:0];
    cur_nxt.top = top_c[DIM_W-1:0];
    cur_nxt.bot = bot_c[DIM_W-1:0];
  end

endmodule

### design/ctt_checker.sv
module ctt_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [ctt_pkg::DIM_W-1:0]   cursor_row,
  input logic [ctt_pkg::DIM_W:0]     cursor_col,
  input logic [ctt_pkg::DIM_W-1:0]   region_top,
  input logic [ctt_pkg::DIM_W-1:0]   region_bottom,
  input logic                        report_request,
  input logic                        sequence_done
);
  import ctt_pkg::*;

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

  // A stalled result word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(cursor_row) && $stable(cursor_col)
      && $stable(region_top) && $stable(region_bottom) && $stable(report_request)
      && $stable(sequence_done))
    else $error("stalled result word changed");

  // An accepted byte reaches the output when the output drains
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready ##1 out_ready |=> out_valid)
    else $error("accepted byte produced no result word");

  // The cursor and region top are one based and never zero
  a_one_based: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cursor_row != '0 && cursor_col != '0 && region_top != '0)
    else $error("cursor or region top reads zero");

  // A report request only ends a sequence
  a_report_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && report_request |-> sequence_done)
    else $error("report request without completed sequence");

endmodule

bind terminal_cursor_tracker_top ctt_checker u_ctt_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .cursor_row     (out_ch.cursor_row),
  .cursor_col     (out_ch.cursor_col),
  .region_top     (out_ch.region_top),
  .region_bottom  (out_ch.region_bottom),
  .report_request (out_ch.report_request),
  .sequence_done  (out_ch.sequence_done)
);
